/* src/scanner_keystroke_filter_unit_macros.svh */
// Assertion helpers for the checker of the key filter.
`ifndef SCANNER_KEYSTROKE_FILTER_UNIT_MACROS_SVH
`define SCANNER_KEYSTROKE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SFK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SFK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sfk_pkg.sv */
package sfk_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int NUM_DIGITS   = 10;
	localparam int DIGIT_W      = 4;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int IDX_W        = $clog2(BUFFER_DEPTH);
	localparam int BUF_W        = BUFFER_DEPTH * DIGIT_W;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W      = 4;
	localparam int REG_IDX_W    = 2;

	localparam logic [7:0] ASCII_ZERO   = 8'd48;
	localparam logic [7:0] ASCII_NINE   = 8'd57;
	localparam logic [7:0] ENTER_NOTIFY = 8'd28;

	localparam logic [15:0] HOLD_THRESHOLD_RST = 16'd20;
	localparam logic [7:0]  ENTER_KEY_RST      = 8'd13;

	localparam logic [1:0] ACT_PASS    = 2'd0;
	localparam logic [1:0] ACT_SWALLOW = 2'd1;
	localparam logic [1:0] ACT_INJECT  = 2'd2;
	localparam logic [1:0] ACT_NOTIFY  = 2'd3;

	localparam logic [1:0] EV_KEY_DOWN = 2'd0;
	localparam logic [1:0] EV_KEY_UP   = 2'd1;
	localparam logic [1:0] EV_SYS_DOWN = 2'd2;
	localparam logic [1:0] EV_SYS_UP   = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BYPASS         = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NOTIFY_ENABLE  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENTER_KEY      = 2'd3;

	typedef struct packed {
		logic [7:0]  key_code;
		logic [1:0]  event_kind;
		logic [31:0] time_ms;
	} sfk_event_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] out_key;
		logic [7:0] notify_value;
		logic       last;
	} sfk_result_t;

	typedef struct packed {
		logic [15:0] hold_threshold_ms;
		logic        bypass;
		logic        notify_enable;
		logic [7:0]  enter_key;
	} sfk_cfg_t;

	typedef enum logic [1:0] {
		CMD_PASS,
		CMD_SWALLOW,
		CMD_INJECT_PASS,
		CMD_FLUSH
	} sfk_cmd_kind_t;

	typedef struct packed {
		sfk_cmd_kind_t    kind;
		logic [7:0]       key;
		logic             matched;
		logic             notify;
		logic [CNT_W-1:0] count;
		logic [BUF_W-1:0] digits;
	} sfk_cmd_t;

	typedef enum logic [2:0] {
		BK_START,
		BK_REPLAY,
		BK_NOTIFY,
		BK_NOTE_ENTER,
		BK_INJECT,
		BK_END
	} sfk_back_state_t;

	function automatic logic prefix_match(input logic [DIGIT_W-1:0] a,
			input logic [DIGIT_W-1:0] b);
		return (a == 4'd1 && b inside {[4'd0:4'd5]}) ||
			(a == 4'd2 && b inside {[4'd5:4'd9]}) ||
			(a == 4'd3 && b == 4'd0);
	endfunction

endpackage

/* src/sfk_front.sv */
module sfk_front (
	input  logic              clk,
	input  logic              arst_n,
	input  sfk_pkg::sfk_cfg_t   cfg,
	input  logic              evt_valid,
	output logic              evt_ready,
	input  sfk_pkg::sfk_event_t evt,
	input  logic              q_full,
	output logic              q_push,
	output sfk_pkg::sfk_cmd_t   q_cmd
);
	import sfk_pkg::*;

	logic                 held_q [NUM_DIGITS];
	logic [31:0]          press_q [NUM_DIGITS];
	logic [DIGIT_W-1:0]   buf_q [BUFFER_DEPTH];
	logic [CNT_W-1:0]     count_q;

	logic                 accept;
	logic                 is_digit;
	logic                 is_press;
	logic [7:0]           key_off;
	logic [DIGIT_W-1:0]   digit;
	logic [31:0]          hold;
	logic                 short_hold;
	logic [BUF_W-1:0]     digits;
	logic                 clr_count;
	logic                 do_press;
	logic                 do_release;
	logic                 do_store;

	assign evt_ready = !q_full;
	assign accept    = evt_valid && !q_full;
	assign q_push    = accept;

	assign is_digit   = evt.key_code >= ASCII_ZERO && evt.key_code <= ASCII_NINE;
	assign is_press   = evt.event_kind == EV_KEY_DOWN || evt.event_kind == EV_SYS_DOWN;
	assign key_off    = evt.key_code - ASCII_ZERO;
	assign digit      = key_off[DIGIT_W-1:0];
	assign hold       = evt.time_ms - press_q[digit];
	assign short_hold = hold < {16'd0, cfg.hold_threshold_ms};

	always_comb begin
		for (int i = 0; i < BUFFER_DEPTH; i++) begin
			digits[i*DIGIT_W +: DIGIT_W] = buf_q[i];
		end
	end

	always_comb begin
		q_cmd.kind    = CMD_PASS;
		q_cmd.key     = evt.key_code;
		q_cmd.matched = count_q >= CNT_W'(2) && prefix_match(buf_q[0], buf_q[1]);
		q_cmd.notify  = cfg.notify_enable;
		q_cmd.count   = count_q;
		q_cmd.digits  = digits;
		clr_count     = 1'b0;
		do_press      = 1'b0;
		do_release    = 1'b0;
		do_store      = 1'b0;
		if (cfg.bypass) begin
			q_cmd.kind = CMD_PASS;
		end else if (evt.key_code == cfg.enter_key) begin
			if (count_q != '0) begin
				q_cmd.kind = CMD_FLUSH;
				clr_count  = 1'b1;
			end
		end else if (!is_digit) begin
			clr_count = 1'b1;
		end else if (is_press) begin
			q_cmd.kind = CMD_SWALLOW;
			do_press   = !held_q[digit];
		end else begin
			do_release = 1'b1;
			if (short_hold) begin
				do_store = count_q < CNT_W'(BUFFER_DEPTH);
			end else begin
				q_cmd.kind = CMD_INJECT_PASS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				held_q[i]  <= 1'b0;
				press_q[i] <= '0;
			end
		end else if (accept) begin
			if (clr_count) begin
				count_q <= '0;
			end else if (do_store) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (do_press) begin
				held_q[digit]  <= 1'b1;
				press_q[digit] <= evt.time_ms;
			end
			if (do_release) begin
				held_q[digit] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_store) begin
			buf_q[count_q[IDX_W-1:0]] <= digit;
		end
	end

endmodule

/* src/sfk_queue.sv */
module sfk_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfk_pkg::sfk_cmd_t cmd_in,
	output logic            full,
	input  logic            pop,
	output sfk_pkg::sfk_cmd_t head,
	output logic            valid
);
	import sfk_pkg::*;

	sfk_cmd_t            entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                do_push;
	logic                do_pop;

	assign full    = fill_q == QCNT_W'(QUEUE_DEPTH);
	assign valid   = fill_q != '0;
	assign head    = entries[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

/* src/sfk_back.sv */
module sfk_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  sfk_pkg::sfk_cmd_t    cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output sfk_pkg::sfk_result_t res
);
	import sfk_pkg::*;

	sfk_back_state_t     state_q;
	sfk_back_state_t     state_d;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    idx_d;
	logic                res_valid_q;
	sfk_result_t         res_q;
	sfk_result_t         res_d;
	logic                emit;
	logic                step;
	logic                idx_last;
	logic [DIGIT_W-1:0]  digit_cur;
	logic [7:0]          digit_key;

	assign step      = cmd_valid && (!res_valid_q || res_ready);
	assign idx_last  = CNT_W'(idx_q + CNT_W'(1)) == cmd.count;
	assign digit_cur = cmd.digits[idx_q[IDX_W-1:0]*DIGIT_W +: DIGIT_W];
	assign digit_key = ASCII_ZERO + {4'd0, digit_cur};
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		emit    = 1'b0;
		cmd_pop = 1'b0;
		res_d   = '0;
		if (step) begin
			case (state_q)
				BK_START: begin
					case (cmd.kind)
						CMD_PASS: begin
							emit         = 1'b1;
							res_d.action = ACT_PASS;
							res_d.last   = 1'b1;
							cmd_pop      = 1'b1;
						end
						CMD_SWALLOW: begin
							emit         = 1'b1;
							res_d.action = ACT_SWALLOW;
							res_d.last   = 1'b1;
							cmd_pop      = 1'b1;
						end
						CMD_INJECT_PASS: begin
							state_d = BK_INJECT;
						end
						CMD_FLUSH: begin
							idx_d = '0;
							if (!cmd.matched) begin
								state_d = BK_REPLAY;
							end else if (cmd.notify) begin
								state_d = BK_NOTIFY;
							end else begin
								state_d = BK_END;
							end
						end
						default: state_d = BK_START;
					endcase
				end
				BK_REPLAY: begin
					emit          = 1'b1;
					res_d.action  = ACT_INJECT;
					res_d.out_key = digit_key;
					if (idx_last) begin
						idx_d   = '0;
						state_d = cmd.notify ? BK_NOTIFY : BK_INJECT;
					end else begin
						idx_d = idx_q + CNT_W'(1);
					end
				end
				BK_NOTIFY: begin
					emit               = 1'b1;
					res_d.action       = ACT_NOTIFY;
					res_d.out_key      = digit_key;
					res_d.notify_value = {4'd0, digit_cur};
					if (idx_last) begin
						idx_d   = '0;
						state_d = BK_NOTE_ENTER;
					end else begin
						idx_d = idx_q + CNT_W'(1);
					end
				end
				BK_NOTE_ENTER: begin
					emit               = 1'b1;
					res_d.action       = ACT_NOTIFY;
					res_d.out_key      = ENTER_NOTIFY;
					res_d.notify_value = ENTER_NOTIFY;
					state_d            = cmd.matched ? BK_END : BK_INJECT;
				end
				BK_INJECT: begin
					emit          = 1'b1;
					res_d.action  = ACT_INJECT;
					res_d.out_key = cmd.key;
					state_d       = BK_END;
				end
				BK_END: begin
					emit         = 1'b1;
					res_d.action = (cmd.kind == CMD_FLUSH) ? ACT_SWALLOW : ACT_PASS;
					res_d.last   = 1'b1;
					cmd_pop      = 1'b1;
					state_d      = BK_START;
				end
				default: state_d = BK_START;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_START;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

endmodule

/* src/scanner_keystroke_filter_unit.sv */
// Scanner keystroke filter. Key events enter on evt; the front end classifies each one in
// the cycle it is taken, updates the per-digit press times and the digit buffer, and posts
// a command into a two-entry queue, so it takes one event per cycle while the queue has room.
// The back end turns each command into results on res from its output register, stalling
// while res_ready is low, and pops the command only with its last result: a plain pass or
// swallow gives a single result, an injected long press an inject and then a pass, and an
// Enter flush of up to 16 buffered digits a sequence in which the sequencer emits, as the
// match and notify enable require, the replayed digits, digit notifications, Enter
// notification, injected Enter and final swallow one after another. The buffer is copied
// into the flush command, so events after an Enter are classified while the flush is still
// being sent. Registers sit on the APB port at byte addresses 0 (hold threshold), 4 (bypass),
// 8 (notify enable) and 12 (Enter key code); write them only while the block is idle. No clearing pass after reset.
module scanner_keystroke_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfk_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          evt_valid,
	output logic                          evt_ready,
	input  sfk_pkg::sfk_event_t           evt,
	output logic                          res_valid,
	input  logic                          res_ready,
	output sfk_pkg::sfk_result_t          res
);
	import sfk_pkg::*;

	sfk_cfg_t              cfg_q;
	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  q_full;
	logic                  q_push;
	sfk_cmd_t              q_cmd;
	logic                  q_valid;
	logic                  q_pop;
	sfk_cmd_t              q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_threshold_ms <= HOLD_THRESHOLD_RST;
			cfg_q.bypass            <= 1'b0;
			cfg_q.notify_enable     <= 1'b0;
			cfg_q.enter_key         <= ENTER_KEY_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_HOLD_THRESHOLD: cfg_q.hold_threshold_ms <= pwdata[15:0];
				REG_BYPASS:         cfg_q.bypass            <= pwdata[0];
				REG_NOTIFY_ENABLE:  cfg_q.notify_enable     <= pwdata[0];
				REG_ENTER_KEY:      cfg_q.enter_key         <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HOLD_THRESHOLD: prdata = {16'd0, cfg_q.hold_threshold_ms};
			REG_BYPASS:         prdata = {31'd0, cfg_q.bypass};
			REG_NOTIFY_ENABLE:  prdata = {31'd0, cfg_q.notify_enable};
			REG_ENTER_KEY:      prdata = {24'd0, cfg_q.enter_key};
			default:            prdata = '0;
		endcase
	end

	sfk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	sfk_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.cmd_in (q_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.valid  (q_valid)
	);

	sfk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

/* src/sfk_checker.sv */
`include "scanner_keystroke_filter_unit_macros.svh"

module sfk_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input sfk_pkg::sfk_result_t          res
);
	import sfk_pkg::*;

	// hold a stalled result transaction
	`SFK_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
	`SFK_ASSERT_NOW(a_plain_zero, res_valid && (res.action == ACT_PASS || res.action == ACT_SWALLOW), res.out_key == 8'd0 && res.notify_value == 8'd0, "pass or swallow carries a key")
	`SFK_ASSERT_NOW(a_value_notify, res_valid && res.action != ACT_NOTIFY, res.notify_value == 8'd0, "value outside a notification")
	`SFK_ASSERT_NOW(a_not_last, res_valid && (res.action == ACT_INJECT || res.action == ACT_NOTIFY), !res.last, "inject or notify marked last")

endmodule

bind scanner_keystroke_filter_unit sfk_checker u_sfk_checker (.*);
